// File: rtl/adf_pkg.sv
// ----------------------------------------------------------------------------
// adf_pkg
// shared types, character codes and the place weight table for the
// ascii decimal to fixed point converter
// ----------------------------------------------------------------------------
package adf_pkg;

   localparam int OUT_FRAC_BITS_DEF    = 32;
   localparam int WEIGHT_FRAC_BITS_DEF = 40;
   localparam int WEIGHT_MAX_BITS      = 49;
   localparam int WIDX_BITS            = 4;
   localparam int WTAB_DEPTH           = 16;
   localparam int QUEUE_DEPTH          = 4;
   localparam int CHAR_W               = 8;
   localparam int DIGIT_W              = 9;
   localparam int VALUE_W              = 64;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'd46;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_NEG,
      OP_INT,
      OP_FRAC,
      OP_END
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [DIGIT_W-1:0]  digit;
      logic [WIDX_BITS-1:0]       widx;
   } qent_type;

   // place weights floor(2^wbits / 10^k), evaluated at elaboration
   function automatic logic [WTAB_DEPTH-1:0][WEIGHT_MAX_BITS-1:0] weight_table(
      input int wbits);
      logic [63:0]                                    v;
      logic [WTAB_DEPTH-1:0][WEIGHT_MAX_BITS-1:0]     tab;
      v = 64'd1 << wbits;
      for (int k = 0; k < WTAB_DEPTH; k++) begin
         tab[k] = v[WEIGHT_MAX_BITS-1:0];
         v      = v / 64'd10;
      end
      return tab;
   endfunction

endpackage

// File: rtl/adf_front.sv
// ----------------------------------------------------------------------------
// adf_front
// accepts characters, tracks the parse phase and queues the operations
// that change the number
// ----------------------------------------------------------------------------
module adf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [adf_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                          q_full,
   output logic                          push,
   output adf_pkg::qent_type             push_entry
);

   typedef enum logic [3:0] {
      PH_SPACE = 4'b0001,
      PH_SIGN  = 4'b0010,
      PH_INT   = 4'b0100,
      PH_FRAC  = 4'b1000
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [adf_pkg::WIDX_BITS-1:0]    fcnt_ff, fcnt_in, fcnt_inc;
   logic                             accept, is_space, done;
   logic signed [adf_pkg::DIGIT_W-1:0] digit;
   phase_type                        ph;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign is_space  = ((req_char_code >= adf_pkg::CHAR_TAB) &&
                       (req_char_code <= adf_pkg::CHAR_CR)) ||
                      (req_char_code == adf_pkg::CHAR_SPACE);
   assign digit     = $signed({1'b0, req_char_code}) - $signed({1'b0, adf_pkg::CHAR_ZERO});
   assign fcnt_inc  = (fcnt_ff == {adf_pkg::WIDX_BITS{1'b1}}) ? fcnt_ff :
                      fcnt_ff + {{(adf_pkg::WIDX_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in         = phase_ff;
      fcnt_in          = fcnt_ff;
      push             = 1'b0;
      push_entry.op    = adf_pkg::OP_INT;
      push_entry.digit = digit;
      push_entry.widx  = fcnt_inc;
      ph               = phase_ff;
      done             = 1'b0;
      if (accept) begin
         if (req_char_code == adf_pkg::CHAR_NUL) begin
            push          = 1'b1;
            push_entry.op = adf_pkg::OP_END;
            ph            = PH_SPACE;
            fcnt_in       = '0;
         end else begin
            if (ph == PH_SPACE) begin
               if (is_space) begin
                  done = 1'b1;
               end else begin
                  ph = PH_SIGN;
               end
            end
            if (!done && ph == PH_SIGN) begin
               if (req_char_code == adf_pkg::CHAR_PLUS) begin
                  done = 1'b1;
               end else if (req_char_code == adf_pkg::CHAR_MINUS) begin
                  done          = 1'b1;
                  push          = 1'b1;
                  push_entry.op = adf_pkg::OP_NEG;
               end else begin
                  ph = PH_INT;
               end
            end
            if (!done && ph == PH_INT) begin
               done = 1'b1;
               if (req_char_code == adf_pkg::CHAR_DOT) begin
                  ph = PH_FRAC;
               end else begin
                  push          = 1'b1;
                  push_entry.op = adf_pkg::OP_INT;
               end
            end
            if (!done && ph == PH_FRAC) begin
               push          = 1'b1;
               push_entry.op = adf_pkg::OP_FRAC;
               fcnt_in       = fcnt_inc;
            end
         end
         phase_in = ph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         fcnt_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         fcnt_ff  <= fcnt_in;
      end
   end

endmodule

// File: rtl/adf_queue.sv
// ----------------------------------------------------------------------------
// adf_queue
// short fifo of decoded operations between the front and the back
// ----------------------------------------------------------------------------
module adf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  adf_pkg::qent_type   push_entry,
   output logic                full,
   input  logic                pop,
   output adf_pkg::qent_type   head,
   output logic                avail
);

   localparam int PTR_W = $clog2(adf_pkg::QUEUE_DEPTH);

   adf_pkg::qent_type    mem_ff [adf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign full  = (count_ff == (PTR_W+1)'(adf_pkg::QUEUE_DEPTH));
   assign avail = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(adf_pkg::QUEUE_DEPTH-1)) ? '0 :
                     wr_ptr_ff + {{(PTR_W-1){1'b0}}, 1'b1};
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(adf_pkg::QUEUE_DEPTH-1)) ? '0 :
                     rd_ptr_ff + {{(PTR_W-1){1'b0}}, 1'b1};
      end
      if (push && !pop) begin
         count_in = count_ff + {{PTR_W{1'b0}}, 1'b1};
      end else if (pop && !push) begin
         count_in = count_ff - {{PTR_W{1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/adf_back.sv
// ----------------------------------------------------------------------------
// adf_back
// executes queued operations: integer accumulate with clamp, fraction
// multiply and accumulate, then result assembly, saturation and sign
// ----------------------------------------------------------------------------
module adf_back #(
   parameter int OUT_FRAC_BITS    = adf_pkg::OUT_FRAC_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = adf_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_avail,
   input  adf_pkg::qent_type                    q_head,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [adf_pkg::VALUE_W-1:0]   rsp_value,
   output logic                                 rsp_overflow
);

   localparam int ISB = adf_pkg::VALUE_W - 1 - OUT_FRAC_BITS;
   localparam int IW  = ISB + 2;
   localparam int CW  = ISB + 6;
   localparam int WW  = WEIGHT_FRAC_BITS + 1;
   localparam int FW  = WEIGHT_FRAC_BITS + 8;
   localparam int TW  = (CW > FW) ? CW : FW;
   localparam int PW  = WW + adf_pkg::DIGIT_W + 1;
   localparam logic [adf_pkg::WTAB_DEPTH-1:0][adf_pkg::WEIGHT_MAX_BITS-1:0] WTAB =
      adf_pkg::weight_table(WEIGHT_FRAC_BITS);
   localparam logic signed [CW-1:0] INT_LIM = $signed(CW'(1) << ISB);
   localparam logic signed [TW-1:0] T_LIM   = $signed(TW'(1) << ISB);

   logic                              en;

   // stage 0: integer and sign state, fraction product
   logic signed [IW-1:0]              int_ff, int_in;
   logic                              neg_ff, neg_in, sat_ff, sat_in;
   logic signed [CW-1:0]              int_ext, int_calc;
   logic signed [IW-1:0]              int_clamp;
   logic                              clamp_hit;
   logic [WW-1:0]                     weight;
   logic signed [PW-1:0]              prod_full;

   // stage 1
   logic                              s1_valid_ff, s1_valid_in;
   adf_pkg::op_type                   s1_op_ff;
   logic signed [FW-1:0]              s1_prod_ff;
   logic signed [IW-1:0]              s1_int_ff;
   logic                              s1_neg_ff, s1_sat_ff;
   logic signed [FW-1:0]              frac_ff, frac_in;
   logic signed [FW-1:0]              frac_q;
   logic signed [FW+OUT_FRAC_BITS-1:0] frac_scaled;
   logic signed [TW-1:0]              t_sum;
   logic [adf_pkg::VALUE_W-1:0]       bits_a;
   logic                              ov_a;

   // stage 2
   logic                              s2_valid_ff, s2_valid_in;
   logic [adf_pkg::VALUE_W-1:0]       s2_bits_ff;
   logic                              s2_ov_ff, s2_neg_ff;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [adf_pkg::VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                              rsp_overflow_ff, rsp_overflow_in;

   assign en    = !rsp_valid_ff || rsp_ready;
   assign q_pop = en && q_avail;

   assign weight    = WTAB[q_head.widx][WW-1:0];
   assign prod_full = PW'(q_head.digit) * PW'($signed({1'b0, weight}));

   assign int_ext  = CW'(int_ff);
   assign int_calc = (int_ext <<< 3) + (int_ext <<< 1) + CW'(q_head.digit);

   always_comb begin
      clamp_hit = 1'b0;
      int_clamp = int_calc[IW-1:0];
      if (int_calc > INT_LIM) begin
         clamp_hit = 1'b1;
         int_clamp = INT_LIM[IW-1:0];
      end else if (int_calc < -INT_LIM) begin
         clamp_hit = 1'b1;
         int_clamp = -(INT_LIM[IW-1:0]);
      end
   end

   always_comb begin
      int_in = int_ff;
      neg_in = neg_ff;
      sat_in = sat_ff;
      if (q_pop) begin
         case (q_head.op)
            adf_pkg::OP_NEG: begin
               neg_in = !neg_ff;
            end
            adf_pkg::OP_INT: begin
               int_in = int_clamp;
               sat_in = sat_ff | clamp_hit;
            end
            adf_pkg::OP_END: begin
               int_in = '0;
               neg_in = 1'b0;
               sat_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_valid_in = en ? q_avail : s1_valid_ff;

   // result assembly
   assign frac_q      = frac_ff >>> WEIGHT_FRAC_BITS;
   assign frac_scaled = $signed({frac_ff, {OUT_FRAC_BITS{1'b0}}}) >>> WEIGHT_FRAC_BITS;
   assign t_sum       = TW'(s1_int_ff) + TW'(frac_q);

   always_comb begin
      ov_a = s1_sat_ff;
      if (t_sum >= T_LIM) begin
         bits_a = adf_pkg::VALUE_MAX;
         ov_a   = 1'b1;
      end else if (t_sum < -T_LIM) begin
         bits_a = adf_pkg::VALUE_MIN;
         ov_a   = 1'b1;
      end else begin
         bits_a = {t_sum[ISB:0], frac_scaled[OUT_FRAC_BITS-1:0]};
      end
   end

   always_comb begin
      frac_in = frac_ff;
      if (en && s1_valid_ff) begin
         case (s1_op_ff)
            adf_pkg::OP_FRAC: frac_in = frac_ff + s1_prod_ff;
            adf_pkg::OP_END:  frac_in = '0;
            default:          frac_in = frac_ff;
         endcase
      end
   end

   assign s2_valid_in = en ? (s1_valid_ff && (s1_op_ff == adf_pkg::OP_END)) : s2_valid_ff;

   // sign application
   always_comb begin
      rsp_overflow_in = s2_ov_ff;
      rsp_value_in    = s2_bits_ff;
      if (s2_neg_ff) begin
         if (s2_bits_ff == adf_pkg::VALUE_MIN) begin
            rsp_value_in    = adf_pkg::VALUE_MAX;
            rsp_overflow_in = 1'b1;
         end else begin
            rsp_value_in = {adf_pkg::VALUE_W{1'b0}} - s2_bits_ff;
         end
      end
   end

   assign rsp_valid_in = en ? s2_valid_ff : rsp_valid_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = $signed(rsp_value_ff);
   assign rsp_overflow = rsp_overflow_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff        <= q_head.op;
         s1_prod_ff      <= prod_full[FW-1:0];
         s1_int_ff       <= int_ff;
         s1_neg_ff       <= neg_ff;
         s1_sat_ff       <= sat_ff;
         s2_bits_ff      <= bits_a;
         s2_ov_ff        <= ov_a;
         s2_neg_ff       <= s1_neg_ff;
         rsp_value_ff    <= rsp_value_in;
         rsp_overflow_ff <= rsp_overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff       <= '0;
         neg_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         frac_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         int_ff       <= int_in;
         neg_ff       <= neg_in;
         sat_ff       <= sat_in;
         frac_ff      <= frac_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/ascii_decimal_to_fixed_point_unit.sv
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_point_unit
// converts a decimal ascii string, one character per request, into a
// signed Q31.32 fixed point value with an overflow flag
// ----------------------------------------------------------------------------
// usage
//   req channel: one character per request on req_char_code (valid/ready).
//   a character of zero ends the string; only that request produces a
//   response on the rsp channel (rsp_value, rsp_overflow, valid/ready).
//   throughput: one request per cycle, sustained while rsp is taken.
//   path: the terminating request passes the queue, the execute stage, the
//   assembly stage and the output register before rsp_valid rises.
//   the front decodes into a 4-entry operation queue; when the receiver
//   stalls, the back holds its pipeline and the queue fills, and req_ready
//   drops only once the queue is full.
//   reset: synchronous; clears the parse state, the queue and the response
//   valid, leaving the block ready for a new string.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_point_unit #(
   parameter int OUT_FRAC_BITS    = adf_pkg::OUT_FRAC_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = adf_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [adf_pkg::CHAR_W-1:0]           req_char_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [adf_pkg::VALUE_W-1:0]   rsp_value,
   output logic                                 rsp_overflow
);

   logic                 push, q_full, q_pop, q_avail;
   adf_pkg::qent_type    push_entry, q_head;

   adf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   adf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .avail      (q_avail)
   );

   adf_back #(
      .OUT_FRAC_BITS    (OUT_FRAC_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_avail      (q_avail),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

endmodule
